// ===== rtl/quaternion_to_rotation_matrix_assert.svh =====
// Assertion macros for the quaternion to rotation matrix block.
`ifndef QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH
`define QUATERNION_TO_ROTATION_MATRIX_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QRM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("qrm: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("qrm: next-cycle check failed");

`endif

// ===== rtl/qrm_pkg.sv =====
// Package: widths, payload types and pipeline constants of the quaternion to matrix block.
package qrm_pkg;

	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 14;

	localparam int N_ENT   = 9;                 // matrix entries, row-major
	localparam int PROD_W  = 2 * DATA_WIDTH;    // one component product
	localparam int DEN_W   = 2 * DATA_WIDTH + 1; // sum of four squares
	localparam int NUM_W   = 2 * DATA_WIDTH + 2; // diagonal sum or doubled cross term
	localparam int QUO_W   = FRAC_BITS + 2;     // quotient scaled by 2^(FRAC_BITS+1)

	localparam int FRONT_STAGES = 4;
	localparam int DIV_STEPS    = FRAC_BITS + 1;
	localparam int N_STAGES     = FRONT_STAGES + DIV_STEPS + 1;

	localparam logic [N_ENT-1:0] DIAG_MASK = 9'b100010001;

	localparam logic [DATA_WIDTH-1:0] ONE_M = DATA_WIDTH'(1) << FRAC_BITS;
	localparam logic [QUO_W-1:0]      ONE_Q = QUO_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quat_w;
		logic signed [DATA_WIDTH-1:0] quat_x;
		logic signed [DATA_WIDTH-1:0] quat_y;
		logic signed [DATA_WIDTH-1:0] quat_z;
	} quat_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] m00;
		logic signed [DATA_WIDTH-1:0] m01;
		logic signed [DATA_WIDTH-1:0] m02;
		logic signed [DATA_WIDTH-1:0] m10;
		logic signed [DATA_WIDTH-1:0] m11;
		logic signed [DATA_WIDTH-1:0] m12;
		logic signed [DATA_WIDTH-1:0] m20;
		logic signed [DATA_WIDTH-1:0] m21;
		logic signed [DATA_WIDTH-1:0] m22;
		logic                         zero_quat;
	} mat_t;

	// State of the nine parallel divisions between pipeline stages.
	typedef struct packed {
		logic [N_ENT-1:0][DEN_W-1:0] rem;
		logic [N_ENT-1:0][QUO_W-1:0] quo;
		logic [DEN_W-1:0]            den;
		logic [N_ENT-1:0]            neg;
		logic                        zero;
	} div_t;

endpackage

// ===== rtl/qrm_if.sv =====
// Stream interfaces: quaternion request channel and matrix result channel.
interface qrm_quat_if;
	logic             valid;
	logic             ready;
	qrm_pkg::quat_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface qrm_mat_if;
	logic             valid;
	logic             ready;
	qrm_pkg::mat_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/quaternion_to_rotation_matrix.sv =====
// Top level: quaternion to 3x3 rotation matrix, streaming pipeline.
//
// Takes one quaternion per cycle while quat.ready is high and returns its row-major rotation matrix,
// each entry the exact ratio to the sum of squares, rounded half away from zero
// to Q1.14 and held within plus or minus one; an all-zero quaternion returns
// the identity with zero_quat set. The pipeline has four front stages
// (products, sums, magnitudes, top quotient bit), one quotient bit per stage
// through FRAC_BITS + 1 restoring division stages shared by all nine entries,
// and a rounding and output register stage.
// Throughput is one matrix per cycle while mat.ready holds; each stage holds its item while the
// next is full, so a stalled result still leaves room for new requests until
// every stage is occupied.
`include "quaternion_to_rotation_matrix_assert.svh"

module quaternion_to_rotation_matrix (
	input  logic        clk,
	input  logic        arst_n,
	qrm_quat_if.sink    quat,
	qrm_mat_if.source   mat
);

	logic [qrm_pkg::N_STAGES-1:0] v_q;
	logic [qrm_pkg::N_STAGES-1:0] en;
	logic [qrm_pkg::N_STAGES-1:0] v_in;

	qrm_pkg::div_t div_pipe [qrm_pkg::DIV_STEPS+1];
	qrm_pkg::mat_t mat_res;

	// A stage advances when it is empty or the stage after it advances.
	always_comb begin
		en[qrm_pkg::N_STAGES-1] = !v_q[qrm_pkg::N_STAGES-1] || mat.ready;
		for (int i = qrm_pkg::N_STAGES - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end

	assign v_in = {v_q[qrm_pkg::N_STAGES-2:0], quat.valid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= (en & v_in) | (~en & v_q);
		end
	end

	qrm_front u_front (
		.clk    (clk),
		.en     (en[qrm_pkg::FRONT_STAGES-1:0]),
		.quat_d (quat.data),
		.div_o  (div_pipe[0])
	);

	for (genvar k = 0; k < qrm_pkg::DIV_STEPS; k++) begin : g_div
		qrm_div_step u_step (
			.clk   (clk),
			.en    (en[qrm_pkg::FRONT_STAGES + k]),
			.div_d (div_pipe[k]),
			.div_o (div_pipe[k+1])
		);
	end

	qrm_back u_back (
		.clk   (clk),
		.en    (en[qrm_pkg::N_STAGES-1]),
		.div_d (div_pipe[qrm_pkg::DIV_STEPS]),
		.mat_o (mat_res)
	);

	assign quat.ready = en[0];
	assign mat.valid  = v_q[qrm_pkg::N_STAGES-1];
	assign mat.data   = mat_res;

	`QRM_ASSERT_NEXT(a_accept_enters, quat.valid && quat.ready, v_q[0])
	`QRM_ASSERT_NOW(a_stall_only_full, !quat.ready, &v_q)
	`QRM_ASSERT_NOW(a_zero_identity, mat.valid && mat.data.zero_quat, mat.data.m00 == qrm_pkg::ONE_M && mat.data.m11 == qrm_pkg::ONE_M && mat.data.m22 == qrm_pkg::ONE_M && mat.data.m01 == '0 && mat.data.m12 == '0 && mat.data.m20 == '0)
	`QRM_ASSERT_NOW(a_entry_bound, mat.valid, mat.data.m01 <= $signed(qrm_pkg::ONE_M) && mat.data.m01 >= -$signed(qrm_pkg::ONE_M) && mat.data.m00 <= $signed(qrm_pkg::ONE_M) && mat.data.m00 >= -$signed(qrm_pkg::ONE_M))

endmodule

// ===== rtl/qrm_front.sv =====
// Front stages: component products, numerator and denominator sums, magnitudes, top quotient bit.
module qrm_front (
	input  logic                                 clk,
	input  logic [qrm_pkg::FRONT_STAGES-1:0]     en,
	input  qrm_pkg::quat_t                       quat_d,
	output qrm_pkg::div_t                        div_o
);

	logic signed [qrm_pkg::PROD_W-1:0] w_c, x_c, y_c, z_c;

	logic signed [qrm_pkg::PROD_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [qrm_pkg::PROD_W-1:0] wx_s1, wy_s1, wz_s1, xy_s1, xz_s1, yz_s1;

	logic signed [qrm_pkg::NUM_W-1:0] eww, exx, eyy, ezz, ewx, ewy, ewz, exy, exz, eyz;
	logic signed [qrm_pkg::NUM_W-1:0] num_c [qrm_pkg::N_ENT];
	logic [qrm_pkg::DEN_W-1:0]        den_c;

	logic signed [qrm_pkg::NUM_W-1:0] num_s2 [qrm_pkg::N_ENT];
	logic [qrm_pkg::DEN_W-1:0]        den_s2;

	logic [qrm_pkg::N_ENT-1:0][qrm_pkg::DEN_W-1:0] mag_c;
	logic [qrm_pkg::N_ENT-1:0][qrm_pkg::DEN_W-1:0] mag_s3;
	logic [qrm_pkg::N_ENT-1:0]                     neg_s3;
	logic [qrm_pkg::DEN_W-1:0]                     den_s3;
	logic                                          zero_s3;

	qrm_pkg::div_t init_c;
	qrm_pkg::div_t div_s4;

	// Sign-extend the components to the product width.
	assign w_c = qrm_pkg::PROD_W'(quat_d.quat_w);
	assign x_c = qrm_pkg::PROD_W'(quat_d.quat_x);
	assign y_c = qrm_pkg::PROD_W'(quat_d.quat_y);
	assign z_c = qrm_pkg::PROD_W'(quat_d.quat_z);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ww_s1 <= w_c * w_c;
			xx_s1 <= x_c * x_c;
			yy_s1 <= y_c * y_c;
			zz_s1 <= z_c * z_c;
			wx_s1 <= w_c * x_c;
			wy_s1 <= w_c * y_c;
			wz_s1 <= w_c * z_c;
			xy_s1 <= x_c * y_c;
			xz_s1 <= x_c * z_c;
			yz_s1 <= y_c * z_c;
		end
	end

	assign eww = qrm_pkg::NUM_W'(ww_s1);
	assign exx = qrm_pkg::NUM_W'(xx_s1);
	assign eyy = qrm_pkg::NUM_W'(yy_s1);
	assign ezz = qrm_pkg::NUM_W'(zz_s1);
	assign ewx = qrm_pkg::NUM_W'(wx_s1);
	assign ewy = qrm_pkg::NUM_W'(wy_s1);
	assign ewz = qrm_pkg::NUM_W'(wz_s1);
	assign exy = qrm_pkg::NUM_W'(xy_s1);
	assign exz = qrm_pkg::NUM_W'(xz_s1);
	assign eyz = qrm_pkg::NUM_W'(yz_s1);

	// Off-diagonal numerators carry the factor two of the rotation formula.
	always_comb begin
		num_c[0] = eww + exx - eyy - ezz;
		num_c[1] = (exy - ewz) <<< 1;
		num_c[2] = (exz + ewy) <<< 1;
		num_c[3] = (exy + ewz) <<< 1;
		num_c[4] = eww - exx + eyy - ezz;
		num_c[5] = (eyz - ewx) <<< 1;
		num_c[6] = (exz - ewy) <<< 1;
		num_c[7] = (eyz + ewx) <<< 1;
		num_c[8] = eww - exx - eyy + ezz;
		den_c    = qrm_pkg::DEN_W'(eww + exx + eyy + ezz);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			num_s2 <= num_c;
			den_s2 <= den_c;
		end
	end

	always_comb begin
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			mag_c[i] = qrm_pkg::DEN_W'(num_s2[i][qrm_pkg::NUM_W-1] ? -num_s2[i] : num_s2[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mag_s3  <= mag_c;
			for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
				neg_s3[i] <= num_s2[i][qrm_pkg::NUM_W-1];
			end
			den_s3  <= den_s2;
			zero_s3 <= (den_s2 == '0);
		end
	end

	// Magnitude never exceeds the denominator, so the top quotient bit is an equality.
	always_comb begin
		init_c.den  = den_s3;
		init_c.neg  = neg_s3;
		init_c.zero = zero_s3;
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			init_c.quo[i] = qrm_pkg::QUO_W'(mag_s3[i] == den_s3);
			init_c.rem[i] = (mag_s3[i] == den_s3) ? '0 : mag_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			div_s4 <= init_c;
		end
	end

	assign div_o = div_s4;

endmodule

// ===== rtl/qrm_div_step.sv =====
// One restoring division step for all nine matrix entries, registered.
module qrm_div_step (
	input  logic          clk,
	input  logic          en,
	input  qrm_pkg::div_t div_d,
	output qrm_pkg::div_t div_o
);

	qrm_pkg::div_t step_c;
	qrm_pkg::div_t step_s;

	always_comb begin
		logic [qrm_pkg::DEN_W:0] shl;
		logic [qrm_pkg::DEN_W:0] dv;
		logic [qrm_pkg::DEN_W:0] diff;
		logic                    ge;
		step_c = div_d;
		dv     = {1'b0, div_d.den};
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			shl  = {div_d.rem[i], 1'b0};
			diff = shl - dv;
			ge   = (shl >= dv);
			step_c.rem[i] = ge ? diff[qrm_pkg::DEN_W-1:0] : shl[qrm_pkg::DEN_W-1:0];
			step_c.quo[i] = {div_d.quo[i][qrm_pkg::QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s <= step_c;
		end
	end

	assign div_o = step_s;

endmodule

// ===== rtl/qrm_back.sv =====
// Output stage: round, saturate, restore sign, substitute identity for a zero quaternion.
module qrm_back (
	input  logic          clk,
	input  logic          en,
	input  qrm_pkg::div_t div_d,
	output qrm_pkg::mat_t mat_o
);

	logic [qrm_pkg::N_ENT-1:0][qrm_pkg::DATA_WIDTH-1:0] ent_c;
	qrm_pkg::mat_t                                      mat_c;
	qrm_pkg::mat_t                                      res_s;

	always_comb begin
		logic [qrm_pkg::QUO_W:0]          inc;
		logic [qrm_pkg::QUO_W-1:0]        rnd;
		logic [qrm_pkg::QUO_W-1:0]        sat;
		logic signed [qrm_pkg::QUO_W:0]   sval;
		for (int i = 0; i < qrm_pkg::N_ENT; i++) begin
			// quotient holds one extra fraction bit: add half and drop it
			inc  = {1'b0, div_d.quo[i]} + (qrm_pkg::QUO_W + 1)'(1);
			rnd  = inc[qrm_pkg::QUO_W:1];
			sat  = (rnd > qrm_pkg::ONE_Q) ? qrm_pkg::ONE_Q : rnd;
			sval = div_d.neg[i] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
			if (div_d.zero) begin
				ent_c[i] = qrm_pkg::DIAG_MASK[i] ? qrm_pkg::ONE_M : '0;
			end else begin
				ent_c[i] = qrm_pkg::DATA_WIDTH'(sval);
			end
		end
		mat_c.m00       = ent_c[0];
		mat_c.m01       = ent_c[1];
		mat_c.m02       = ent_c[2];
		mat_c.m10       = ent_c[3];
		mat_c.m11       = ent_c[4];
		mat_c.m12       = ent_c[5];
		mat_c.m20       = ent_c[6];
		mat_c.m21       = ent_c[7];
		mat_c.m22       = ent_c[8];
		mat_c.zero_quat = div_d.zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s <= mat_c;
		end
	end

	assign mat_o = res_s;

endmodule
